### rtl/lrus_pkg.sv
package lrus_pkg;

    // geometry
    localparam int NUM_SETS    = 64;
    localparam int ASSOC       = 8;
    localparam int SET_W       = $clog2(NUM_SETS);
    localparam int WAY_W       = $clog2(ASSOC);
    localparam int ROW_W       = ASSOC * WAY_W;
    localparam int CMD_W       = 3;
    localparam int ALLOC_W     = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [ALLOC_W-1:0] ALLOC_RESET = ALLOC_W'(8);

    // command codes on the input word
    localparam logic [CMD_W-1:0] CMD_TOUCH       = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_FILL        = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_STREAM_FILL = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_INVALIDATE  = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_FIND_VICTIM = CMD_W'(4);

    typedef logic [WAY_W-1:0] way_t;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_TO_FRONT,
        OP_TO_BACK,
        OP_VICTIM
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [SET_W-1:0] set_index;
        way_t             way;
    } item_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // order word after reset: way p sits at position p
    function automatic logic [ROW_W-1:0] reset_row();
        logic [ROW_W-1:0] r;
        r = '0;
        for (int p = 0; p < ASSOC; p++)
        begin
            r[p*WAY_W +: WAY_W] = WAY_W'(p);
        end
        return r;
    endfunction

endpackage

### rtl/lrus_front.sv
module lrus_front
    import lrus_pkg::*;
(
    input  logic               push,
    input  logic [CMD_W-1:0]   command,
    input  logic [SET_W-1:0]   set_index,
    input  logic [WAY_W-1:0]   way,
    output logic               full,
    input  logic               q_full,
    output logic               q_push,
    output item_t              q_item
);

    logic keep;
    logic set_ok;
    logic way_ok;
    op_t  op_sel;

    // range checks on the incoming word
    assign set_ok = ({1'b0, set_index} < (SET_W+1)'(NUM_SETS));
    assign way_ok = ({1'b0, way} < (WAY_W+1)'(ASSOC));

    // classify; words that change nothing are taken and dropped here
    always_comb
    begin
        keep   = 1'b0;
        op_sel = OP_VICTIM;
        case (command)
            CMD_TOUCH, CMD_FILL:
            begin
                keep   = set_ok && way_ok;
                op_sel = OP_TO_FRONT;
            end
            CMD_STREAM_FILL, CMD_INVALIDATE:
            begin
                keep   = set_ok && way_ok;
                op_sel = OP_TO_BACK;
            end
            CMD_FIND_VICTIM:
            begin
                keep   = set_ok;
                op_sel = OP_VICTIM;
            end
            default:
            begin
                keep   = 1'b0;
                op_sel = OP_VICTIM;
            end
        endcase
    end

    assign q_item = {op_sel, set_index, way};

    assign full   = q_full;
    assign q_push = push && !q_full && keep;

endmodule

### rtl/lrus_queue.sv
module lrus_queue
    import lrus_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  item_t  push_item,
    output logic   full,
    input  logic   pop,
    output item_t  head_item,
    output logic   empty
);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

### rtl/lrus_back.sv
module lrus_back
    import lrus_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  item_t              q_item,
    output logic               q_pop,
    input  logic               alloc_ways_valid,
    output logic               alloc_ways_ready,
    input  logic [ALLOC_W-1:0] alloc_ways,
    input  logic               pop,
    output logic               empty,
    output logic [WAY_W-1:0]   victim_way
);

    state_t               state_reg;
    state_t               state_next;
    item_t                item_reg;
    logic [ROW_W-1:0]     mem [NUM_SETS];
    logic [NUM_SETS-1:0]  set_valid_reg;
    logic [ROW_W-1:0]     rd_row_reg;
    logic                 rd_hit_reg;
    logic [ALLOC_W-1:0]   alloc_ways_reg;
    logic                 out_valid_reg;
    way_t                 victim_way_reg;

    logic [ROW_W-1:0]     cur_row;
    logic [ROW_W-1:0]     row_next;
    way_t                 cur [ASSOC];
    way_t                 upd [ASSOC];
    way_t                 pos;
    way_t                 victim_next;
    logic                 victim_found;
    logic                 exec_go;
    logic                 mem_we;
    logic                 out_push;

    // configuration register
    assign alloc_ways_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_ways_reg <= ALLOC_RESET;
        end
        else if (alloc_ways_valid)
        begin
            alloc_ways_reg <= alloc_ways;
        end
    end

    // order word of the set in hand; an unwritten set reads as the reset order
    assign cur_row = rd_hit_reg ? rd_row_reg : reset_row();

    always_comb
    begin
        for (int q = 0; q < ASSOC; q++)
        begin
            cur[q] = cur_row[q*WAY_W +: WAY_W];
        end
    end

    // position of the named way
    always_comb
    begin
        pos = '0;
        for (int q = 0; q < ASSOC; q++)
        begin
            if (cur[q] == item_reg.way)
            begin
                pos = WAY_W'(q);
            end
        end
    end

    // move to the most-recent or least-recent end
    always_comb
    begin
        for (int q = 0; q < ASSOC; q++)
        begin
            upd[q] = cur[q];
        end
        if (item_reg.op == OP_TO_FRONT)
        begin
            upd[0] = item_reg.way;
            for (int q = 1; q < ASSOC; q++)
            begin
                upd[q] = (WAY_W'(q) <= pos) ? cur[q-1] : cur[q];
            end
        end
        else
        begin
            for (int q = 0; q < ASSOC - 1; q++)
            begin
                upd[q] = (WAY_W'(q) >= pos) ? cur[q+1] : cur[q];
            end
            upd[ASSOC-1] = item_reg.way;
        end
        for (int q = 0; q < ASSOC; q++)
        begin
            row_next[q*WAY_W +: WAY_W] = upd[q];
        end
    end

    // victim: allocatable way nearest the least-recent end
    always_comb
    begin
        victim_found = 1'b0;
        victim_next  = '0;
        for (int q = 0; q < ASSOC; q++)
        begin
            if (ALLOC_W'(cur[q]) < alloc_ways_reg)
            begin
                victim_found = 1'b1;
                victim_next  = cur[q];
            end
        end
    end

    // a victim waits only while the result slot is held
    assign exec_go = !(item_reg.op == OP_VICTIM && victim_found && out_valid_reg && !pop);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop    = 1'b0;
        mem_we   = 1'b0;
        out_push = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop = !q_empty;
            end
            ST_EXEC:
            begin
                mem_we   = exec_go && (item_reg.op != OP_VICTIM);
                out_push = exec_go && (item_reg.op == OP_VICTIM) && victim_found;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            set_valid_reg <= '0;
            rd_hit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                rd_hit_reg <= set_valid_reg[q_item.set_index];
            end
            if (mem_we)
            begin
                set_valid_reg[item_reg.set_index] <= 1'b1;
            end
            if (out_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // order memory with registered read, and payload registers
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[item_reg.set_index] <= row_next;
        end
        if (q_pop)
        begin
            rd_row_reg <= mem[q_item.set_index];
            item_reg   <= q_item;
        end
        if (out_push)
        begin
            victim_way_reg <= victim_next;
        end
    end

    assign empty      = !out_valid_reg;
    assign victim_way = victim_way_reg;

    a_victim_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (ALLOC_W'(victim_next) < alloc_ways_reg))
        else $error("victim outside allocatable ways");

    a_pop_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && q_pop) |=> (state_reg == ST_EXEC))
        else $error("word taken without execution");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(victim_way_reg)))
        else $error("waiting result lost");

endmodule

### rtl/lru_replacement_with_stream_insert.sv
// channel     | direction | handshake                      | payload
// input       | in        | push / full                    | command, set_index, way
// result      | out       | pop / empty                    | victim_way
// alloc_ways  | in        | alloc_ways_valid / ..._ready   | alloc_ways
//
// in the back end, an idle state does the registered read of the set's order
// word, and an exec state updates it or picks the victim and writes back.
// the front end takes a word each cycle while its two-entry queue has room.
// reset (rst_n low) gives every set the order way 0 .. way 7 without a sweep.
// a victim stalls in the back end only while the previous result is not popped.
module lru_replacement_with_stream_insert
    import lrus_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [CMD_W-1:0]   command,
    input  logic [SET_W-1:0]   set_index,
    input  logic [WAY_W-1:0]   way,
    output logic               empty,
    input  logic               pop,
    output logic [WAY_W-1:0]   victim_way,
    input  logic               alloc_ways_valid,
    output logic               alloc_ways_ready,
    input  logic [ALLOC_W-1:0] alloc_ways
);

    logic  q_full;
    logic  q_push;
    item_t q_in_item;
    logic  q_pop;
    logic  q_empty;
    item_t q_head_item;

    // accept and classify
    lrus_front u_front (
        .push      (push),
        .command   (command),
        .set_index (set_index),
        .way       (way),
        .full      (full),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in_item)
    );

    // decoupling queue
    lrus_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (q_head_item),
        .empty     (q_empty)
    );

    // order update and victim search
    lrus_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_item           (q_head_item),
        .q_pop            (q_pop),
        .alloc_ways_valid (alloc_ways_valid),
        .alloc_ways_ready (alloc_ways_ready),
        .alloc_ways       (alloc_ways),
        .pop              (pop),
        .empty            (empty),
        .victim_way       (victim_way)
    );

endmodule
